// ----- hw/rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// Field widths, request and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  localparam int TYPE_W = 2;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 13;
  localparam int OFF_W  = 12;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 12;

  typedef enum logic [TYPE_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_PEEK    = 2'd1,
    REQ_CONSUME = 2'd2,
    REQ_FIND    = 2'd3
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_SHORT    = 3'd3,
    ST_CLAMPED  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/brb_if.sv -----
// ----------------------------------------------------------------------------
// brb_if: request and result channels of the byte ring buffer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface brb_req_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [DATA_W-1:0] payload;
  logic [CNT_W-1:0]  count;
  logic [OFF_W-1:0]  peek_offset;
  logic [CNT_W-1:0]  search_limit;

  modport source (output valid, req_type, payload, count, peek_offset, search_limit,
                  input ready);
  modport sink   (input valid, req_type, payload, count, peek_offset, search_limit,
                  output ready);
endinterface

interface brb_rsp_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] read_bytes;
  logic [IDX_W-1:0]  match_index;
  logic [CNT_W-1:0]  bytes_consumed;
  logic [CNT_W-1:0]  readable_count;
  logic [CNT_W-1:0]  writable_count;

  modport source (output valid, status, read_bytes, match_index, bytes_consumed,
                  readable_count, writable_count, input ready);
  modport sink   (input valid, status, read_bytes, match_index, bytes_consumed,
                  readable_count, writable_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/brb_byte_mem.sv -----
// ----------------------------------------------------------------------------
// brb_byte_mem: byte-wide store of the ring buffer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_byte_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/byte_ring_buffer_with_search.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_search: circular byte store with pattern search
// Requests enter on req; each gives exactly one item on rsp. A write stores
// one byte a cycle, a peek reads one byte a cycle through the single memory
// read port, and a find streams stored bytes from the head one a cycle past
// a compare window until the first match or the end of the searched span.
// The searched span is the search limit cut to the fill count. Only one
// request is in flight: req.ready is high only while the sequencer is idle.
// A finished result waits in the rsp output register while the next request
// is accepted and worked on; a stalled rsp holds its item, and the sequencer
// waits at the end of the following request until the register frees. Reset
// empties the buffer (head, tail and fill count zero) and drops any pending
// result; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_with_search import brb_pkg::*; #(
  parameter int CAPACITY           = 4096,
  parameter int MAX_BYTES_PER_ITEM = 8
) (
  input  logic  clk,
  input  logic  rst,
  brb_req_if.sink   req,
  brb_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = ((FW > CNT_W) ? FW : CNT_W) + 1;

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [FW-1:0]     fill, fill_next;
  req_kind_t         kind, kind_next;
  logic [DATA_W-1:0] wbuf, wbuf_next;
  logic [3:0]        wleft, wleft_next;
  logic [3:0]        plen, plen_next;
  logic [DATA_W-1:0] apat, apat_next;
  logic [DATA_W-1:0] amask, amask_next;
  logic [DATA_W-1:0] win, win_next;
  logic [AW-1:0]     raddr, raddr_next;
  logic [CW-1:0]     iss_left, iss_left_next;
  logic [CW-1:0]     rcv, rcv_next;
  logic [CW-1:0]     scan_n, scan_n_next;
  status_t           res_status, res_status_next;
  logic [DATA_W-1:0] res_rbytes, res_rbytes_next;
  logic [IDX_W-1:0]  res_midx, res_midx_next;
  logic [CNT_W-1:0]  res_consumed, res_consumed_next;

  logic              ov, ov_next;
  logic [STAT_W-1:0] out_status, out_status_next;
  logic [DATA_W-1:0] out_rbytes, out_rbytes_next;
  logic [IDX_W-1:0]  out_midx, out_midx_next;
  logic [CNT_W-1:0]  out_consumed, out_consumed_next;
  logic [CNT_W-1:0]  out_readable, out_readable_next;
  logic [CNT_W-1:0]  out_writable, out_writable_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        rdata;
  logic              rvalid;

  logic [CW-1:0]     cnt_c, fill_c, cap_c, lim_c, span_c, cons_c, sum_c, rcv_inc;
  logic              bad_len, match;
  logic [3:0]        cnt4;
  logic [6:0]        sh;
  logic [DATA_W-1:0] win_shift;

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
    return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
  endfunction

  brb_byte_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = ov;
  assign rsp.status         = out_status;
  assign rsp.read_bytes     = out_rbytes;
  assign rsp.match_index    = out_midx;
  assign rsp.bytes_consumed = out_consumed;
  assign rsp.readable_count = out_readable;
  assign rsp.writable_count = out_writable;

  always_comb begin
    cnt_c     = CW'(req.count);
    fill_c    = CW'(fill);
    cap_c     = CW'(CAPACITY);
    lim_c     = CW'(req.search_limit);
    bad_len   = (req.count == '0) || (req.count > CNT_W'(MAX_BYTES_PER_ITEM));
    cnt4      = req.count[3:0];
    sh        = {4'd8 - cnt4, 3'b000};
    span_c    = ((lim_c != '0) && (lim_c < fill_c)) ? lim_c : fill_c;
    cons_c    = (cnt_c > fill_c) ? fill_c : cnt_c;
    sum_c     = '0;
    rcv_inc   = rcv + CW'(1);
    win_shift = {rdata, win[DATA_W-1:8]};
    match     = (((win_shift ^ apat) & amask) == '0) && (rcv_inc >= CW'(plen));

    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    fill_next         = fill;
    kind_next         = kind;
    wbuf_next         = wbuf;
    wleft_next        = wleft;
    plen_next         = plen;
    apat_next         = apat;
    amask_next        = amask;
    win_next          = win;
    raddr_next        = raddr;
    iss_left_next     = iss_left;
    rcv_next          = rcv;
    scan_n_next       = scan_n;
    res_status_next   = res_status;
    res_rbytes_next   = res_rbytes;
    res_midx_next     = res_midx;
    res_consumed_next = res_consumed;

    ov_next           = ov && !rsp.ready;
    out_status_next   = out_status;
    out_rbytes_next   = out_rbytes;
    out_midx_next     = out_midx;
    out_consumed_next = out_consumed;
    out_readable_next = out_readable;
    out_writable_next = out_writable;

    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wdata = wbuf[7:0];
    mem_re    = 1'b0;
    mem_raddr = raddr;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next         = req_kind_t'(req.req_type);
          res_status_next   = ST_OK;
          res_rbytes_next   = '0;
          res_midx_next     = '0;
          res_consumed_next = '0;
          plen_next         = cnt4;
          rcv_next          = '0;
          state_next        = S_DONE;
          case (req_kind_t'(req.req_type))
            REQ_WRITE: begin
              if (bad_len) begin
                res_status_next = ST_INVALID;
              end else if (cnt_c > cap_c - fill_c) begin
                res_status_next = ST_FULL;
              end else begin
                wbuf_next  = req.payload;
                wleft_next = cnt4;
                state_next = S_WRITE;
              end
            end
            REQ_PEEK: begin
              if (bad_len) begin
                res_status_next = ST_INVALID;
              end else if (CW'(req.peek_offset) + cnt_c > fill_c) begin
                res_status_next = ST_SHORT;
              end else begin
                sum_c         = CW'(head) + CW'(req.peek_offset);
                raddr_next    = (sum_c >= cap_c) ? AW'(sum_c - cap_c) : AW'(sum_c);
                iss_left_next = cnt_c;
                scan_n_next   = cnt_c;
                state_next    = S_SCAN;
              end
            end
            REQ_CONSUME: begin
              if (cnt_c > fill_c) begin
                res_status_next = ST_CLAMPED;
              end
              sum_c             = CW'(head) + cons_c;
              head_next         = (sum_c >= cap_c) ? AW'(sum_c - cap_c) : AW'(sum_c);
              fill_next         = FW'(fill_c - cons_c);
              res_consumed_next = CNT_W'(cons_c);
            end
            REQ_FIND: begin
              if (bad_len) begin
                res_status_next = ST_INVALID;
              end else if ((fill == '0) || (span_c < cnt_c)) begin
                res_status_next = ST_NOTFOUND;
              end else begin
                raddr_next    = head;
                iss_left_next = span_c;
                scan_n_next   = span_c;
                apat_next     = req.payload << sh;
                amask_next    = {DATA_W{1'b1}} << sh;
                state_next    = S_SCAN;
              end
            end
            default: begin
              res_status_next = ST_INVALID;
            end
          endcase
        end
      end

      S_WRITE: begin
        mem_we     = 1'b1;
        tail_next  = inc_wrap(tail);
        wbuf_next  = wbuf >> 8;
        wleft_next = wleft - 4'd1;
        if (wleft == 4'd1) begin
          fill_next  = fill + FW'(plen);
          state_next = S_DONE;
        end
      end

      S_SCAN: begin
        if (iss_left != '0) begin
          mem_re        = 1'b1;
          raddr_next    = inc_wrap(raddr);
          iss_left_next = iss_left - CW'(1);
        end
        if (rvalid) begin
          rcv_next = rcv_inc;
          if (kind == REQ_PEEK) begin
            res_rbytes_next[{rcv[2:0], 3'b000} +: 8] = rdata;
            if (rcv_inc == scan_n) begin
              state_next = S_DONE;
            end
          end else begin
            win_next = win_shift;
            if (match) begin
              res_midx_next = IDX_W'(rcv_inc - CW'(plen));
              state_next    = S_DONE;
            end else if (rcv_inc == scan_n) begin
              res_status_next = ST_NOTFOUND;
              state_next      = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        if (!ov || rsp.ready) begin
          ov_next           = 1'b1;
          out_status_next   = res_status;
          out_rbytes_next   = res_rbytes;
          out_midx_next     = res_midx;
          out_consumed_next = res_consumed;
          out_readable_next = CNT_W'(fill_c);
          out_writable_next = CNT_W'(cap_c - fill_c);
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
      ov     <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      fill   <= fill_next;
      ov     <= ov_next;
      rvalid <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    kind         <= kind_next;
    wbuf         <= wbuf_next;
    wleft        <= wleft_next;
    plen         <= plen_next;
    apat         <= apat_next;
    amask        <= amask_next;
    win          <= win_next;
    raddr        <= raddr_next;
    iss_left     <= iss_left_next;
    rcv          <= rcv_next;
    scan_n       <= scan_n_next;
    res_status   <= res_status_next;
    res_rbytes   <= res_rbytes_next;
    res_midx     <= res_midx_next;
    res_consumed <= res_consumed_next;
    out_status   <= out_status_next;
    out_rbytes   <= out_rbytes_next;
    out_midx     <= out_midx_next;
    out_consumed <= out_consumed_next;
    out_readable <= out_readable_next;
    out_writable <= out_writable_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/brb_checker.sv -----
// ----------------------------------------------------------------------------
// brb_checker: port-level checks for the byte ring buffer
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_checker import brb_pkg::*; #(
  parameter int CAPACITY = 4096
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [STAT_W-1:0] status,
  input wire logic [DATA_W-1:0] read_bytes,
  input wire logic [IDX_W-1:0]  match_index,
  input wire logic [CNT_W-1:0]  readable_count,
  input wire logic [CNT_W-1:0]  writable_count
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_bytes))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one still in work");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CNT_W'(readable_count + writable_count) == CNT_W'(CAPACITY)))
    else $error("readable and writable counts do not add up to capacity");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (read_bytes == '0) && (match_index == '0))
    else $error("failed request carries data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result item present after reset");

endmodule

bind byte_ring_buffer_with_search brb_checker #(
  .CAPACITY (CAPACITY)
) u_brb_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .read_bytes     (rsp.read_bytes),
  .match_index    (rsp.match_index),
  .readable_count (rsp.readable_count),
  .writable_count (rsp.writable_count)
);

`default_nettype wire
